[design/otgcr_pkg.sv]
package otgcr_pkg;

  // Frame geometry and decode limits.
  localparam int MaxFrameSamples = 1024;
  localparam int SamplesPerBit   = 3;
  localparam int FrameBits       = 21;
  localparam int MinFrameBits    = 18;
  localparam int StartMargin     = (FrameBits - 2) * SamplesPerBit + 1;
  localparam int WindowLast      = (FrameBits + 2) * SamplesPerBit - 1;
  localparam int BitTotalMax     = 63;

  // Sample counter holds the frame limit itself; stored edge indexes stay below it.
  localparam int SampleCntW = $clog2(MaxFrameSamples + 1);
  localparam int SampleIdxW = $clog2(MaxFrameSamples);

  localparam int PortW   = 16;
  localparam int PinW    = 4;
  localparam int GcrW    = FrameBits;
  localparam int ShiftW  = 32;
  localparam int TotalW  = 6;
  localparam int RunLenW = 5;

  // Configuration port.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic [0:0] {
    REG_PIN_SELECT = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NONE    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

endpackage

[design/otgcr_sample_if.sv]
interface otgcr_sample_if;
  logic                             valid;
  logic                             ready;
  logic [otgcr_pkg::PortW-1:0]      port_word;
  logic                             frame_end;

  modport source (output valid, output port_word, output frame_end, input ready);
  modport sink   (input valid, input port_word, input frame_end, output ready);
endinterface

[design/otgcr_result_if.sv]
interface otgcr_result_if;
  logic                             valid;
  logic                             ready;
  logic [otgcr_pkg::GcrW-1:0]       gcr_word;
  logic [1:0]                       status;

  modport source (output valid, output gcr_word, output status, input ready);
  modport sink   (input valid, input gcr_word, input status, output ready);
endinterface

[design/oversampled_telemetry_gcr_recover_unit.sv]
// Recovers a 21-bit GCR telemetry frame from a stream of 3x-oversampled port words.
// The sample_i channel carries one port capture per word, with frame_end set on the
// last capture of a frame. The line is the port bit chosen by the pin_select register, which
// the user must write at APB byte address 0 only while the block is idle; it is not enforced.
// The result_o channel delivers one word per frame: the recovered gcr_word and status
// (ok, no telemetry found, or invalid because too many bits were found).
// Throughput is one sample word per cycle while no frame_end word is held by a stalled result.
// A word is accepted into an input register and decoded there against the frame state; a
// frame result is registered into the output register when its frame_end word is decoded.
// When the receiver stalls, the result waits in the output register; samples of the
// next frame keep flowing, and only a second frame_end word reaching the decode stage
// holds the input channel until the pending result is taken.
// Reset clears the frame state, pin_select and both stage valids; no clearing pass.
module oversampled_telemetry_gcr_recover_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  otgcr_sample_if.sink                      sample_i,
  otgcr_result_if.source                    result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [otgcr_pkg::ApbAddrW-1:0]    paddr,
  input  logic [otgcr_pkg::ApbDataW-1:0]    pwdata,
  output logic [otgcr_pkg::ApbDataW-1:0]    prdata,
  output logic                              pready
);

  localparam int CntW = otgcr_pkg::SampleCntW;
  localparam int IdxW = otgcr_pkg::SampleIdxW;

  // Configuration register.
  logic [otgcr_pkg::PinW-1:0] pin_select_q;
  logic                       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[otgcr_pkg::ApbAddrW-1:2] == otgcr_pkg::REG_PIN_SELECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_select_q <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      pin_select_q <= pwdata[otgcr_pkg::PinW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(otgcr_pkg::ApbDataW - otgcr_pkg::PinW){1'b0}}, pin_select_q};
    end
  end

  // Input register.
  logic                        in_valid_q;
  logic [otgcr_pkg::PortW-1:0] in_word_q;
  logic                        in_last_q;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        proc;

  assign out_free       = !out_valid_q || result_o.ready;
  assign proc           = in_valid_q && (!in_last_q || out_free);
  assign sample_i.ready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_word_q <= sample_i.port_word;
      in_last_q <= sample_i.frame_end;
    end
  end

  // Frame state.
  logic [CntW-1:0]                sample_idx_q, sample_idx_d;
  logic                           start_found_q, start_found_d;
  logic [IdxW-1:0]                start_idx_q, start_idx_d;
  logic                           want_high_q, want_high_d;
  logic [IdxW-1:0]                last_edge_q, last_edge_d;
  logic [otgcr_pkg::ShiftW-1:0]   shift_q, shift_d;
  logic [otgcr_pkg::TotalW-1:0]   bit_total_q, bit_total_d;

  // Decode signals.
  logic                           level;
  logic                           in_range;
  logic                           in_window;
  logic [CntW-1:0]                run_dist;
  logic [7:0]                     run_num;
  logic [15:0]                    run_prod;
  logic [otgcr_pkg::RunLenW-1:0]  run_len;
  logic [otgcr_pkg::TotalW:0]     total_sum;
  logic                           no_start_room;
  logic [1:0]                     pad_n;
  logic [otgcr_pkg::ShiftW-1:0]   padded;
  otgcr_pkg::status_e             status_d;
  logic [otgcr_pkg::GcrW-1:0]     gcr_d;

  // Run length is (distance + 1) / 3, at least one bit; distance stays below 70
  // inside the edge window, so a multiply by 171 and shift by 9 divides exactly.
  always_comb begin
    level     = in_word_q[pin_select_q];
    in_range  = sample_idx_q < CntW'(otgcr_pkg::MaxFrameSamples);
    in_window = ({1'b0, sample_idx_q}) <=
                ({2'b0, start_idx_q} + (CntW + 1)'(otgcr_pkg::WindowLast));
    run_dist  = sample_idx_q - {1'b0, last_edge_q};
    run_num   = {1'b0, run_dist[6:0]} + 8'd1;
    run_prod  = {8'd0, run_num} * 16'd171;
    run_len   = run_prod[13:9];
    if (run_len == '0) begin
      run_len = otgcr_pkg::RunLenW'(1);
    end
    total_sum = {1'b0, bit_total_q} + {2'b0, run_len};
  end

  // Next frame state for the word in the decode stage.
  always_comb begin
    sample_idx_d  = sample_idx_q;
    start_found_d = start_found_q;
    start_idx_d   = start_idx_q;
    want_high_d   = want_high_q;
    last_edge_d   = last_edge_q;
    shift_d       = shift_q;
    bit_total_d   = bit_total_q;
    if (in_range) begin
      if (!start_found_q) begin
        if (!level) begin
          start_found_d = 1'b1;
          start_idx_d   = sample_idx_q[IdxW-1:0];
          last_edge_d   = sample_idx_q[IdxW-1:0];
          want_high_d   = 1'b1;
        end
      end else if (!in_last_q && in_window && (level == want_high_q)) begin
        shift_d     = (shift_q << run_len) |
                      (otgcr_pkg::ShiftW'(1) << (run_len - otgcr_pkg::RunLenW'(1)));
        bit_total_d = (total_sum > (otgcr_pkg::TotalW + 1)'(otgcr_pkg::BitTotalMax)) ?
                      otgcr_pkg::TotalW'(otgcr_pkg::BitTotalMax) :
                      total_sum[otgcr_pkg::TotalW-1:0];
        last_edge_d = sample_idx_q[IdxW-1:0];
        want_high_d = !want_high_q;
      end
      sample_idx_d = sample_idx_q + CntW'(1);
    end
  end

  // Frame verdict and padding of the final run.
  always_comb begin
    no_start_room = ({2'b0, start_idx_d} + (CntW + 1)'(otgcr_pkg::StartMargin)) >=
                    {1'b0, sample_idx_d};
    pad_n  = 2'(otgcr_pkg::FrameBits) - bit_total_d[1:0];
    padded = shift_d << pad_n;
    if (pad_n != 2'd0) begin
      padded = padded | (otgcr_pkg::ShiftW'(1) << (pad_n - 2'd1));
    end
    gcr_d    = '0;
    status_d = otgcr_pkg::STATUS_OK;
    if (!start_found_d || no_start_room ||
        (bit_total_d < otgcr_pkg::TotalW'(otgcr_pkg::MinFrameBits))) begin
      status_d = otgcr_pkg::STATUS_NONE;
    end else if (bit_total_d > otgcr_pkg::TotalW'(otgcr_pkg::FrameBits)) begin
      status_d = otgcr_pkg::STATUS_INVALID;
    end else begin
      gcr_d = padded[otgcr_pkg::GcrW-1:0];
    end
  end

  // Frame state registers; a frame_end word returns them to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_idx_q  <= '0;
      start_found_q <= 1'b0;
      start_idx_q   <= '0;
      want_high_q   <= 1'b1;
      last_edge_q   <= '0;
      shift_q       <= '0;
      bit_total_q   <= '0;
    end else if (proc) begin
      if (in_last_q) begin
        sample_idx_q  <= '0;
        start_found_q <= 1'b0;
        start_idx_q   <= '0;
        want_high_q   <= 1'b1;
        last_edge_q   <= '0;
        shift_q       <= '0;
        bit_total_q   <= '0;
      end else begin
        sample_idx_q  <= sample_idx_d;
        start_found_q <= start_found_d;
        start_idx_q   <= start_idx_d;
        want_high_q   <= want_high_d;
        last_edge_q   <= last_edge_d;
        shift_q       <= shift_d;
        bit_total_q   <= bit_total_d;
      end
    end
  end

  // Output register.
  logic [otgcr_pkg::GcrW-1:0] out_gcr_q;
  otgcr_pkg::status_e         out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      out_gcr_q    <= gcr_d;
      out_status_q <= status_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.gcr_word = out_gcr_q;
  assign result_o.status   = out_status_q;

  // A failed frame never carries a recovered word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != otgcr_pkg::STATUS_OK)) |-> (out_gcr_q == '0))
    else $error("nonzero gcr word with failing status");

  // Closing a frame returns the frame state to its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |=> ((sample_idx_q == '0) && !start_found_q && (bit_total_q == '0)))
    else $error("frame state not cleared after frame end");

  // No bits collect before the start sample is found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_found_q |-> ((bit_total_q == '0) && (shift_q == '0)))
    else $error("bits collected before frame start");

  // A stalled result is not overwritten or dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> (out_valid_q && $stable(out_gcr_q)))
    else $error("pending result lost during stall");

endmodule
